// ===== rtl/core/shl_pkg.sv =====
// Shared types and character codes for the command-line lexer.
`timescale 1ns / 1ps
package shl_pkg;

  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_SQ   = 2'd2,
    MODE_DQ   = 2'd3
  } lex_mode_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_LT   = 2'd1,
    PEND_GT   = 2'd2
  } pend_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_EOW  = 2'd1,
    KIND_OP   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    TT_WORD    = 3'd0,
    TT_PIPE    = 3'd1,
    TT_HEREDOC = 3'd2,
    TT_APPEND  = 3'd3,
    TT_IN      = 3'd4,
    TT_OUT     = 3'd5
  } tok_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    tok_e       tt;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [1:0]        cnt;
    lex_mode_e         mode;
    pend_e             pend;
  } step_t;

endpackage

// ===== rtl/core/shl_step.sv =====
// Next-state and result logic for one input byte of the lexer.
`timescale 1ns / 1ps
module shl_step (
  input  shl_pkg::lex_mode_e mode_i,
  input  shl_pkg::pend_e     pend_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output shl_pkg::step_t     step_o
);

  shl_pkg::res_t [shl_pkg::MaxRes-1:0] res;
  logic [1:0]         n;
  shl_pkg::lex_mode_e mode;
  shl_pkg::pend_e     pend;
  logic               consumed;
  logic               held_op;
  logic [7:0]         held_ch;

  always_comb begin
    res      = '0;
    n        = 2'd0;
    mode     = mode_i;
    pend     = pend_i;
    consumed = 1'b0;
    held_op  = (pend_i == shl_pkg::PEND_LT) || (pend_i == shl_pkg::PEND_GT);
    held_ch  = (pend_i == shl_pkg::PEND_LT) ? shl_pkg::CH_LT : shl_pkg::CH_GT;

    if (held_op) begin
      res[n].kind = shl_pkg::KIND_OP;
      if (byte_i == held_ch) begin
        res[n].tt = (pend_i == shl_pkg::PEND_LT) ? shl_pkg::TT_HEREDOC : shl_pkg::TT_APPEND;
        consumed  = 1'b1;
      end else begin
        res[n].tt = (pend_i == shl_pkg::PEND_LT) ? shl_pkg::TT_IN : shl_pkg::TT_OUT;
      end
      n    = n + 2'd1;
      mode = shl_pkg::MODE_IDLE;
    end
    pend = shl_pkg::PEND_NONE;

    if (!consumed) begin
      if (mode == shl_pkg::MODE_SQ || mode == shl_pkg::MODE_DQ) begin
        if (byte_i == ((mode == shl_pkg::MODE_SQ) ? shl_pkg::CH_SQ : shl_pkg::CH_DQ)) begin
          mode = shl_pkg::MODE_WORD;
        end else begin
          res[n].kind = shl_pkg::KIND_BYTE;
          res[n].ch   = byte_i;
          n           = n + 2'd1;
        end
      end else if (byte_i == shl_pkg::CH_SPACE || byte_i == shl_pkg::CH_TAB ||
                   byte_i == shl_pkg::CH_PIPE || byte_i == shl_pkg::CH_LT ||
                   byte_i == shl_pkg::CH_GT) begin
        if (mode != shl_pkg::MODE_IDLE) begin
          res[n].kind = shl_pkg::KIND_EOW;
          n           = n + 2'd1;
        end
        mode = shl_pkg::MODE_IDLE;
        if (byte_i == shl_pkg::CH_PIPE) begin
          res[n].kind = shl_pkg::KIND_OP;
          res[n].tt   = shl_pkg::TT_PIPE;
          n           = n + 2'd1;
        end else if (byte_i == shl_pkg::CH_LT) begin
          pend = shl_pkg::PEND_LT;
        end else if (byte_i == shl_pkg::CH_GT) begin
          pend = shl_pkg::PEND_GT;
        end
      end else if (byte_i == shl_pkg::CH_SQ) begin
        mode = shl_pkg::MODE_SQ;
      end else if (byte_i == shl_pkg::CH_DQ) begin
        mode = shl_pkg::MODE_DQ;
      end else begin
        res[n].kind = shl_pkg::KIND_BYTE;
        res[n].ch   = byte_i;
        n           = n + 2'd1;
        mode        = shl_pkg::MODE_WORD;
      end
    end

    if (last_i) begin
      if (mode != shl_pkg::MODE_IDLE) begin
        res[n].kind = shl_pkg::KIND_EOW;
        n           = n + 2'd1;
      end
      if (pend != shl_pkg::PEND_NONE) begin
        res[n].kind = shl_pkg::KIND_OP;
        res[n].tt   = (pend == shl_pkg::PEND_LT) ? shl_pkg::TT_IN : shl_pkg::TT_OUT;
        n           = n + 2'd1;
      end
      mode = shl_pkg::MODE_IDLE;
      pend = shl_pkg::PEND_NONE;
      case (n)
        2'd1:    res[0].last = 1'b1;
        2'd2:    res[1].last = 1'b1;
        2'd3:    res[2].last = 1'b1;
        default: ;
      endcase
    end

    step_o.res  = res;
    step_o.cnt  = n;
    step_o.mode = mode;
    step_o.pend = pend;
  end

endmodule

// ===== rtl/core/shell_command_line_lexer.sv =====
// Top level of the streaming command-line lexer.
// Output: the first result of a byte is registered and valid in the cycle after its input beat.
// Throughput: one byte per cycle while each byte yields at most one result and the output is ready;
// a byte yielding more results stalls input while the result register drains to its last result.
// Reset: asynchronous, active low; lexer returns between tokens with no held operator
// and the result register empty.
`timescale 1ns / 1ps
module shell_command_line_lexer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_req_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] char_out_o,
  output logic [2:0] token_type_o,
  output logic       line_last_o
);

  shl_pkg::lex_mode_e mode_q;
  shl_pkg::pend_e     pend_q;
  shl_pkg::res_t [shl_pkg::MaxRes-1:0] res_q;
  logic [1:0]         cnt_q, cnt_d;
  logic [1:0]         idx_q, idx_d;
  shl_pkg::step_t     step;
  shl_pkg::res_t      head;
  logic               in_fire, out_fire;

  shl_step u_step (
    .mode_i (mode_q),
    .pend_i (pend_q),
    .byte_i (byte_req_i),
    .last_i (line_end_i),
    .step_o (step)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (in_fire) begin
      cnt_d = step.cnt;
      idx_d = 2'd0;
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= shl_pkg::MODE_IDLE;
      pend_q <= shl_pkg::PEND_NONE;
      cnt_q  <= 2'd0;
      idx_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      if (in_fire) begin
        mode_q <= step.mode;
        pend_q <= step.pend;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= step.res;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    head = res_q[0];
      2'd1:    head = res_q[1];
      2'd2:    head = res_q[2];
      default: head = res_q[0];
    endcase
  end

  assign kind_o       = head.kind;
  assign char_out_o   = head.ch;
  assign token_type_o = head.tt;
  assign line_last_o  = head.last;

endmodule

// ===== rtl/core/shl_checker.sv =====
// Port-level checks for the command-line lexer, bound to the top level.
`timescale 1ns / 1ps
module shl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] char_out_o,
  input logic [2:0] token_type_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped before it was taken");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result pending");

  a_word_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != shl_pkg::KIND_OP |-> token_type_o == shl_pkg::TT_WORD)
    else $error("word beat carries an operator type");

  a_op_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == shl_pkg::KIND_OP |->
      token_type_o != shl_pkg::TT_WORD && char_out_o == 8'd0)
    else $error("malformed operator beat");

endmodule

bind shell_command_line_lexer shl_checker u_shl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .char_out_o   (char_out_o),
  .token_type_o (token_type_o)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for the command-line lexer: directed rows, then random command lines and byte runs.
`timescale 1ns / 1ps
module tb_top;

  localparam int RandItems  = 300;
  localparam int HoldCycles = 400;
  localparam int PRED       = -1;
  localparam shl_pkg::res_t NIL = shl_pkg::res_t'(0);

  typedef struct {
    logic [7:0]             ch;
    logic                   eol;
    int                     n_typed;
    shl_pkg::res_t [1:0]    typed;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready_o;
  logic [7:0] byte_req;
  logic       line_end;
  logic       out_valid_o;
  logic       out_ready;
  logic [1:0] kind_o;
  logic [7:0] char_out_o;
  logic [2:0] token_type_o;
  logic       line_last_o;

  shl_pkg::lex_mode_e lx_mode;
  shl_pkg::pend_e     lx_pend;
  shl_pkg::res_t      lexed_q[$];
  shl_pkg::res_t      tok_expect_q[$];
  stim_row_t          dir_q[$];
  logic [7:0]         line_q[$];

  bit calm;
  bit held_done;
  int beats_in;
  int n_lines;
  int n_results;
  int n_eow;
  int n_ops;
  int n_bad;
  int hold_cycles;

  shell_command_line_lexer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .byte_req_i   (byte_req),
    .line_end_i   (line_end),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .kind_o       (kind_o),
    .char_out_o   (char_out_o),
    .token_type_o (token_type_o),
    .line_last_o  (line_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic shl_pkg::res_t tok(shl_pkg::kind_e k, logic [7:0] ch, shl_pkg::tok_e tt,
                                        logic l);
    shl_pkg::res_t r;
    r.kind = k;
    r.ch   = ch;
    r.tt   = tt;
    r.last = l;
    return r;
  endfunction

  function automatic stim_row_t row(logic [7:0] ch, logic eol, int n, shl_pkg::res_t r0,
                                    shl_pkg::res_t r1);
    stim_row_t r;
    r.ch       = ch;
    r.eol      = eol;
    r.n_typed  = n;
    r.typed[0] = r0;
    r.typed[1] = r1;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126))
                                      : 8'($urandom_range(0, 255));
    end while (c == shl_pkg::CH_SPACE || c == shl_pkg::CH_TAB || c == shl_pkg::CH_PIPE ||
               c == shl_pkg::CH_LT || c == shl_pkg::CH_GT || c == shl_pkg::CH_SQ ||
               c == shl_pkg::CH_DQ);
    return c;
  endfunction

  function automatic logic [7:0] quoted_char(logic [7:0] q);
    logic [7:0] c;
    do begin
      c = $urandom_range(0, 1) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
    end while (c == q);
    return c;
  endfunction

  function automatic void emit_tok(shl_pkg::kind_e k, logic [7:0] ch, shl_pkg::tok_e tt);
    lexed_q.push_back(tok(k, ch, tt, 1'b0));
  endfunction

  function automatic void close_word();
    if (lx_mode != shl_pkg::MODE_IDLE) emit_tok(shl_pkg::KIND_EOW, 8'h00, shl_pkg::TT_WORD);
    lx_mode = shl_pkg::MODE_IDLE;
  endfunction

  // Advance the lexer state by one byte and collect the tokens it yields.
  function automatic void lex_byte(logic [7:0] c, logic eol);
    logic eaten;
    eaten = 1'b0;
    lexed_q.delete();
    if (lx_pend == shl_pkg::PEND_LT || lx_pend == shl_pkg::PEND_GT) begin
      if (c == ((lx_pend == shl_pkg::PEND_LT) ? shl_pkg::CH_LT : shl_pkg::CH_GT)) begin
        emit_tok(shl_pkg::KIND_OP, 8'h00,
                 (lx_pend == shl_pkg::PEND_LT) ? shl_pkg::TT_HEREDOC : shl_pkg::TT_APPEND);
        eaten = 1'b1;
      end else begin
        emit_tok(shl_pkg::KIND_OP, 8'h00,
                 (lx_pend == shl_pkg::PEND_LT) ? shl_pkg::TT_IN : shl_pkg::TT_OUT);
      end
      lx_mode = shl_pkg::MODE_IDLE;
    end
    lx_pend = shl_pkg::PEND_NONE;
    if (!eaten) begin
      if (lx_mode == shl_pkg::MODE_SQ || lx_mode == shl_pkg::MODE_DQ) begin
        if (c == ((lx_mode == shl_pkg::MODE_SQ) ? shl_pkg::CH_SQ : shl_pkg::CH_DQ))
          lx_mode = shl_pkg::MODE_WORD;
        else emit_tok(shl_pkg::KIND_BYTE, c, shl_pkg::TT_WORD);
      end else if (c == shl_pkg::CH_SPACE || c == shl_pkg::CH_TAB) begin
        close_word();
      end else if (c == shl_pkg::CH_PIPE) begin
        close_word();
        emit_tok(shl_pkg::KIND_OP, 8'h00, shl_pkg::TT_PIPE);
      end else if (c == shl_pkg::CH_LT || c == shl_pkg::CH_GT) begin
        close_word();
        lx_pend = (c == shl_pkg::CH_LT) ? shl_pkg::PEND_LT : shl_pkg::PEND_GT;
      end else if (c == shl_pkg::CH_SQ) begin
        lx_mode = shl_pkg::MODE_SQ;
      end else if (c == shl_pkg::CH_DQ) begin
        lx_mode = shl_pkg::MODE_DQ;
      end else begin
        emit_tok(shl_pkg::KIND_BYTE, c, shl_pkg::TT_WORD);
        lx_mode = shl_pkg::MODE_WORD;
      end
    end
    if (eol) begin
      close_word();
      if (lx_pend != shl_pkg::PEND_NONE)
        emit_tok(shl_pkg::KIND_OP, 8'h00,
                 (lx_pend == shl_pkg::PEND_LT) ? shl_pkg::TT_IN : shl_pkg::TT_OUT);
      lx_pend = shl_pkg::PEND_NONE;
      lx_mode = shl_pkg::MODE_IDLE;
      if (lexed_q.size() > 0) lexed_q[lexed_q.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic send_row(input stim_row_t r);
    int g;
    byte_req <= r.ch;
    line_end <= r.eol;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    lex_byte(r.ch, r.eol);
    if (r.n_typed == PRED) begin
      foreach (lexed_q[i]) tok_expect_q.push_back(lexed_q[i]);
    end else begin
      for (int i = 0; i < r.n_typed; i++) tok_expect_q.push_back(r.typed[i]);
    end
    beats_in++;
    if (r.eol) n_lines++;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic build_line();
    int ntok;
    int sel;
    logic [7:0] q;
    line_q.delete();
    ntok = $urandom_range(1, 5);
    for (int t = 0; t < ntok; t++) begin
      repeat ((t == 0) ? $urandom_range(0, 1) : $urandom_range(0, 2))
        line_q.push_back($urandom_range(0, 1) ? shl_pkg::CH_SPACE : shl_pkg::CH_TAB);
      sel = $urandom_range(0, 9);
      if (sel == 7) begin
        line_q.push_back(shl_pkg::CH_PIPE);
      end else if (sel == 8 || sel == 9) begin
        q = (sel == 8) ? shl_pkg::CH_LT : shl_pkg::CH_GT;
        line_q.push_back(q);
        if ($urandom_range(0, 1)) line_q.push_back(q);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 4)) line_q.push_back(plain_char());
          end else begin
            q = $urandom_range(0, 1) ? shl_pkg::CH_SQ : shl_pkg::CH_DQ;
            line_q.push_back(q);
            repeat ($urandom_range(0, 4)) line_q.push_back(quoted_char(q));
            if ($urandom_range(0, 19) != 0) line_q.push_back(q);
          end
        end
      end
    end
    if ($urandom_range(0, 4) == 0)
      line_q.push_back($urandom_range(0, 1) ? shl_pkg::CH_SPACE : shl_pkg::CH_TAB);
  endtask

  initial begin : rx
    int g;
    out_ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_done && beats_in >= 100) begin
        held_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) begin
          @(posedge clk_i);
          hold_cycles++;
        end
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : mon
    shl_pkg::res_t got;
    shl_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      got.kind = shl_pkg::kind_e'(kind_o);
      got.ch   = char_out_o;
      got.tt   = shl_pkg::tok_e'(token_type_o);
      got.last = line_last_o;
      n_results++;
      if (got.kind == shl_pkg::KIND_EOW) n_eow++;
      if (got.kind == shl_pkg::KIND_OP) n_ops++;
      if (tok_expect_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected beat: kind %0d ch %h tt %0d last %b",
                   got.kind, got.ch, got.tt, got.last);
      end else begin
        want = tok_expect_q.pop_front();
        if (got.kind !== want.kind || got.ch !== want.ch || got.tt !== want.tt ||
            got.last !== want.last) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"mismatch at beat %0d: exp kind %0d ch %h tt %0d last %b, ",
                      "got kind %0d ch %h tt %0d last %b"},
                     n_results, want.kind, want.ch, want.tt, want.last,
                     got.kind, got.ch, got.tt, got.last);
        end
      end
    end
  end

  initial begin : drv
    int stop_at;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    byte_req = 8'h00;
    line_end = 1'b0;
    lx_mode  = shl_pkg::MODE_IDLE;
    lx_pend  = shl_pkg::PEND_NONE;

    dir_q.push_back(row("a", 1'b0, 1,
                        tok(shl_pkg::KIND_BYTE, "a", shl_pkg::TT_WORD, 1'b0), NIL));
    dir_q.push_back(row(8'h00, 1'b0, 1,
                        tok(shl_pkg::KIND_BYTE, 8'h00, shl_pkg::TT_WORD, 1'b0), NIL));
    dir_q.push_back(row(8'hFF, 1'b0, 1,
                        tok(shl_pkg::KIND_BYTE, 8'hFF, shl_pkg::TT_WORD, 1'b0), NIL));
    dir_q.push_back(row(shl_pkg::CH_SPACE, 1'b0, 1,
                        tok(shl_pkg::KIND_EOW, 8'h00, shl_pkg::TT_WORD, 1'b0), NIL));
    dir_q.push_back(row(shl_pkg::CH_PIPE, 1'b1, 1,
                        tok(shl_pkg::KIND_OP, 8'h00, shl_pkg::TT_PIPE, 1'b1), NIL));
    dir_q.push_back(row(shl_pkg::CH_SPACE, 1'b1, 0, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_LT, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_LT, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_GT, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_GT, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row("x", 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_GT, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row("z", 1'b1, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_SQ, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_PIPE, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_SPACE, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_SQ, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_DQ, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_GT, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_DQ, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_SPACE, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_DQ, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_DQ, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_TAB, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_SQ, 1'b0, PRED, NIL, NIL));
    dir_q.push_back(row("q", 1'b1, PRED, NIL, NIL));
    dir_q.push_back(row(shl_pkg::CH_LT, 1'b1, 1,
                        tok(shl_pkg::KIND_OP, 8'h00, shl_pkg::TT_IN, 1'b1), NIL));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[i]) send_row(dir_q[i]);

    stop_at = beats_in + RandItems;
    while (beats_in < stop_at) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) != 0) begin
        build_line();
        foreach (line_q[i])
          send_row(row(line_q[i], i == line_q.size() - 1, PRED, NIL, NIL));
      end else begin
        repeat ($urandom_range(1, 10))
          send_row(row($urandom_range(0, 1) ? 8'($urandom_range(32, 126))
                                            : 8'($urandom_range(0, 255)),
                       $urandom_range(0, 3) == 0, PRED, NIL, NIL));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (tok_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes over %0d lines; checked %0d beats (%0d word ends, %0d operators).",
             beats_in, n_lines, n_results, n_eow, n_ops);
    $display("Output held off for %0d cycles once; %0d mismatching beats.", hold_cycles, n_bad);
    if (n_bad == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
